// File: rtl/tqps_pkg.sv
// Shared codes and types of the two-queue strict-priority scheduler.
`default_nettype none
package tqps_pkg;

  // Request type codes carried on req_type.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_HIGH = 2'd1;
  localparam logic [1:0] REQ_LOW  = 2'd2;

  // Result outcome codes.
  localparam logic [2:0] OUT_ACCEPTED    = 3'd0;
  localparam logic [2:0] OUT_REFUSED     = 3'd1;
  localparam logic [2:0] OUT_IDLE        = 3'd2;
  localparam logic [2:0] OUT_SERVED_HIGH = 3'd3;
  localparam logic [2:0] OUT_SERVED_LOW  = 3'd4;

  // Register index, taken from paddr[2].
  localparam logic REG_OCC_LIMIT = 1'b0;

  localparam logic [4:0] OCC_LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic        idle;
    logic        high_srv;
    logic        low_srv;
    logic        high_ref;
    logic        low_ref;
    logic [15:0] wait_val;
  } stats_event_t;

endpackage
`default_nettype wire

// File: rtl/tqps_fifo.sv
// Bounded circular queue with a configurable limit and a registered head entry.
`default_nettype none
module tqps_fifo #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  tqps_pkg::fifo_ctrl_t                  ctrl,
  input  wire  [31:0]                           entry,
  input  wire  [4:0]                            limit,
  output logic                                  full,
  output logic [$clog2(QUEUE_DEPTH + 1) - 1:0]  count,
  output logic [31:0]                           head_data
);
  import tqps_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = CW + 1;
  localparam int LW = CW + 5;

  logic [31:0]   mem [QUEUE_DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count_next;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [LW-1:0] lim_ext;
  logic [LW-1:0] depth_ext;
  logic [LW-1:0] eff_limit;
  logic [LW-1:0] count_ext;

  always_comb begin
    lim_ext   = {{CW{1'b0}}, limit};
    depth_ext = LW'(QUEUE_DEPTH);
    eff_limit = (lim_ext > depth_ext) ? depth_ext : lim_ext;
    count_ext = {5'b0, count};
    full      = (count_ext >= eff_limit);

    tail_sum = SW'(head) + SW'(count);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SW'(QUEUE_DEPTH);
    end
    tail = tail_sum[AW-1:0];

    head_next  = head;
    count_next = count;
    if (ctrl.pop) begin
      head_next  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
      count_next = count - CW'(1);
    end else if (ctrl.push) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // The head entry is read ahead; a push into an empty queue bypasses the memory.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= entry;
    end
    if (ctrl.push && count == '0) begin
      head_data <= entry;
    end else begin
      head_data <= mem[head_next];
    end
  end

endmodule
`default_nettype wire

// File: rtl/tqps_stats.sv
// Saturating service, idle, refusal and wait-sum counters.
`default_nettype none
module tqps_stats (
  input  wire                    clk,
  input  wire                    rst,
  input  tqps_pkg::stats_event_t ev,
  output logic [31:0]            idle_ticks,
  output logic [31:0]            high_served,
  output logic [31:0]            low_served,
  output logic [31:0]            high_wait_sum,
  output logic [31:0]            low_wait_sum,
  output logic [31:0]            high_refused,
  output logic [31:0]            low_refused
);
  import tqps_pkg::*;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks    <= '0;
      high_served   <= '0;
      low_served    <= '0;
      high_wait_sum <= '0;
      low_wait_sum  <= '0;
      high_refused  <= '0;
      low_refused   <= '0;
    end else begin
      if (ev.idle) begin
        idle_ticks <= sat_add(idle_ticks, 16'd1);
      end
      if (ev.high_srv) begin
        high_served   <= sat_add(high_served, 16'd1);
        high_wait_sum <= sat_add(high_wait_sum, ev.wait_val);
      end
      if (ev.low_srv) begin
        low_served   <= sat_add(low_served, 16'd1);
        low_wait_sum <= sat_add(low_wait_sum, ev.wait_val);
      end
      if (ev.high_ref) begin
        high_refused <= sat_add(high_refused, 16'd1);
      end
      if (ev.low_ref) begin
        low_refused <= sat_add(low_refused, 16'd1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/two_queue_priority_scheduler.sv
// A request is held in the input register, then its result in the result register, where it
// waits until out_ready takes it.
// Throughput: one item per cycle unless the result stalls; each makes at most one queue push or
// pop. A stalled result holds the input register, so one more item is taken while it waits.
// Reset is synchronous and active high: it clears pointers, occupancies, counters and handshake
// state and sets the occupancy limit to 16; queue storage is not cleared and needs no clearing.
`default_nettype none
module two_queue_priority_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  req_type,
  input  wire  [15:0] plane_id,
  input  wire  [15:0] plane_start,
  input  wire  [15:0] now_time,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  outcome,
  output logic [15:0] served_id,
  output logic [15:0] wait_time,
  output logic [4:0]  high_depth,
  output logic [4:0]  low_depth,
  output logic [31:0] idle_ticks,
  output logic [31:0] high_served,
  output logic [31:0] low_served,
  output logic [31:0] high_wait_sum,
  output logic [31:0] low_wait_sum,
  output logic [31:0] high_refused,
  output logic [31:0] low_refused,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tqps_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic         s1_valid;
  logic [1:0]   s1_type;
  logic [15:0]  s1_id;
  logic [15:0]  s1_start;
  logic [15:0]  s1_now;
  logic         advance;
  logic [4:0]   occ_limit;

  fifo_ctrl_t    hi_ctrl;
  fifo_ctrl_t    lo_ctrl;
  logic          hi_full;
  logic          lo_full;
  logic [CW-1:0] hi_count;
  logic [CW-1:0] lo_count;
  logic [31:0]   hi_head;
  logic [31:0]   lo_head;
  logic [31:0]   entry;
  logic [CW+4:0] hi_count_ext;
  logic [CW+4:0] lo_count_ext;

  logic         is_high;
  logic         is_low;
  logic         is_tick;
  logic [31:0]  srv_entry;
  logic [15:0]  srv_wait;
  logic [2:0]   outcome_next;
  logic [15:0]  served_id_next;
  logic [15:0]  wait_time_next;
  stats_event_t ev;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OCC_LIMIT) ? {27'b0, occ_limit} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ_limit <= OCC_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_OCC_LIMIT) begin
      occ_limit <= pwdata[4:0];
    end
  end

  // Input register.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type  <= req_type;
      s1_id    <= plane_id;
      s1_start <= plane_start;
      s1_now   <= now_time;
    end
  end

  // Decision logic; an unused request type acts as a service tick.
  always_comb begin
    is_high = (s1_type == REQ_HIGH);
    is_low  = (s1_type == REQ_LOW);
    is_tick = !is_high && !is_low;
    entry   = {s1_id, s1_start};

    hi_ctrl.push = advance && is_high && !hi_full;
    lo_ctrl.push = advance && is_low && !lo_full;
    hi_ctrl.pop  = advance && is_tick && (hi_count != '0);
    lo_ctrl.pop  = advance && is_tick && (hi_count == '0) && (lo_count != '0);

    srv_entry = (hi_count != '0) ? hi_head : lo_head;
    srv_wait  = (s1_now >= srv_entry[15:0]) ? (s1_now - srv_entry[15:0]) : 16'd0;

    served_id_next = 16'd0;
    wait_time_next = 16'd0;
    if (is_high) begin
      outcome_next = hi_full ? OUT_REFUSED : OUT_ACCEPTED;
    end else if (is_low) begin
      outcome_next = lo_full ? OUT_REFUSED : OUT_ACCEPTED;
    end else if (hi_count != '0 || lo_count != '0) begin
      outcome_next   = (hi_count != '0) ? OUT_SERVED_HIGH : OUT_SERVED_LOW;
      served_id_next = srv_entry[31:16];
      wait_time_next = srv_wait;
    end else begin
      outcome_next = OUT_IDLE;
    end

    ev.idle     = advance && is_tick && (hi_count == '0) && (lo_count == '0);
    ev.high_srv = hi_ctrl.pop;
    ev.low_srv  = lo_ctrl.pop;
    ev.high_ref = advance && is_high && hi_full;
    ev.low_ref  = advance && is_low && lo_full;
    ev.wait_val = srv_wait;
  end

  tqps_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_high_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (hi_ctrl),
    .entry     (entry),
    .limit     (occ_limit),
    .full      (hi_full),
    .count     (hi_count),
    .head_data (hi_head)
  );

  tqps_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_low_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lo_ctrl),
    .entry     (entry),
    .limit     (occ_limit),
    .full      (lo_full),
    .count     (lo_count),
    .head_data (lo_head)
  );

  // Counters and occupancies move only when a result is loaded, so they always
  // match the result currently held for transfer.
  tqps_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .ev            (ev),
    .idle_ticks    (idle_ticks),
    .high_served   (high_served),
    .low_served    (low_served),
    .high_wait_sum (high_wait_sum),
    .low_wait_sum  (low_wait_sum),
    .high_refused  (high_refused),
    .low_refused   (low_refused)
  );

  assign hi_count_ext = {5'b0, hi_count};
  assign lo_count_ext = {5'b0, lo_count};
  assign high_depth   = hi_count_ext[4:0];
  assign low_depth    = lo_count_ext[4:0];

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      outcome   <= outcome_next;
      served_id <= served_id_next;
      wait_time <= wait_time_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tqps_checker.sv
// Port-level checks of the scheduler and their binding to the top level.
`default_nettype none
module tqps_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  outcome,
  input wire [15:0] served_id,
  input wire [15:0] wait_time,
  input wire [4:0]  high_depth,
  input wire [4:0]  low_depth,
  input wire [31:0] high_served,
  input wire [31:0] low_served
);
  import tqps_pkg::*;

  // A result waiting for transfer keeps its outcome.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome))
    else $error("result changed while stalled");

  // Only a service carries an id and a wait.
  a_no_service_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != OUT_SERVED_HIGH && outcome != OUT_SERVED_LOW
      |-> served_id == 16'd0 && wait_time == 16'd0)
    else $error("id or wait on a non-service result");

  // An idle tick means both queues were empty and still are.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_IDLE |-> high_depth == 5'd0 && low_depth == 5'd0)
    else $error("idle tick with a queue occupied");

  // A low-class service happens only with the high queue empty.
  a_low_priority: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_SERVED_LOW |-> high_depth == 5'd0 && low_served != 32'd0)
    else $error("low class served ahead of high class");

  a_high_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_SERVED_HIGH |-> high_served != 32'd0)
    else $error("high service not counted");

endmodule

bind two_queue_priority_scheduler tqps_checker u_tqps_checker (.*);
`default_nettype wire
